// ===== sv/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths, types and codes of the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = DIFF_W + COORD_W;
    localparam int DIST_W          = PROD_W + 2;
    localparam int DEN_W           = DIST_W + 1;
    localparam int T_FRAC          = 30;
    localparam int T_W             = T_FRAC + 1;
    localparam int NORM_STAGES     = 3;
    localparam int DIV_STAGES      = T_W;
    localparam int CARRY_N         = NORM_STAGES + DIV_STAGES + 1;
    localparam int ISECT_LAT       = CARRY_N + 1;
    localparam int TRI_W           = 9 * COORD_W;
    localparam int CFG_AW          = 3;

    localparam logic [COORD_W-1:0] NORMAL_Z_RST = COORD_W'(1) << COORD_FRAC_BITS;

    // one vertex: x in the lowest bits, then y, then z
    typedef logic [2:0][COORD_W-1:0] t_vec;
    // three vertices, first vertex in the lowest bits
    typedef t_vec [2:0] t_tri;
    typedef logic signed [DIST_W-1:0] t_dist;

    typedef enum logic [1:0] {
        MODE_CULL,
        MODE_PASS,
        MODE_ONE,
        MODE_TWO
    } t_mode;

    // what travels beside the intersection lanes
    typedef struct packed {
        t_mode mode;
        t_vec  p0;
        t_vec  p1;
        t_vec  p2;
    } t_side;

endpackage

// ===== sv/triangle_plane_clipper_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_plane_clipper_unit
// Clips triangles against a configured plane, emits zero to two triangles.
// ----------------------------------------------------------------------------
// usage:
// - s_axis carries one triangle per transaction, nine signed Q16.16 words
// - m_axis carries result triangles; tlast marks the final one of an input
// - the cfg channel writes plane point (indexes 0..2) and normal (3..5);
//   o_cfg_ready is always high, other indexes are ignored; write only idle
// - a second result follows in the cycle after the first one is taken
// - throughput: one triangle per cycle when it gives at most one result and
//   m_axis is ready; one giving two holds input while the second is held
// - distance uses three lanes (one per vertex), intersections use two
//   lanes each with a 31-stage restoring divider
// - reset clears all valid state and loads the plane z = 0, normal +z
// - when m_axis stalls with a result pending, the whole pipeline holds and
//   s_axis_tready drops; culled triangles leave without waiting
// ----------------------------------------------------------------------------
module triangle_plane_clipper_unit import tpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z
    input  logic [TRI_W-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_a_x, out_a_y, out_a_z, out_b_x .. out_c_z
    output logic [TRI_W-1:0]  m_axis_tdata,
    output logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [COORD_W-1:0] i_cfg_data
);

    localparam logic [CFG_AW-1:0] CFG_PPX = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_PPY = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] CFG_PPZ = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] CFG_NX  = CFG_AW'(3);
    localparam logic [CFG_AW-1:0] CFG_NY  = CFG_AW'(4);
    localparam logic [CFG_AW-1:0] CFG_NZ  = CFG_AW'(5);

    t_vec                    r_pp;
    t_vec                    r_nrm;
    logic                    w_en;
    logic                    w_take_ok;
    logic                    r_s0_vld;
    logic                    r_s1_vld;
    logic                    r_s2_vld;
    logic                    r_s3_vld;
    t_tri                    r_s0_v;
    t_tri                    r_s1_v;
    t_tri                    r_s2_v;
    t_dist                   w_dist [3];
    t_side                   r_s3_side;
    t_side                   n_s3_side;
    t_vec                    r_l_vin  [2];
    t_vec                    n_l_vin  [2];
    t_vec                    r_l_vout [2];
    t_vec                    n_l_vout [2];
    t_dist                   r_l_num  [2];
    t_dist                   n_l_num  [2];
    logic signed [DEN_W-1:0] r_l_den  [2];
    logic signed [DEN_W-1:0] n_l_den  [2];
    t_vec                    w_x      [2];
    t_side                   r_dly     [ISECT_LAT];
    logic                    r_dly_vld [ISECT_LAT];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp  <= '0;
            r_nrm <= {NORMAL_Z_RST, {COORD_W{1'b0}}, {COORD_W{1'b0}}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_PPX: r_pp[0]  <= i_cfg_data;
                CFG_PPY: r_pp[1]  <= i_cfg_data;
                CFG_PPZ: r_pp[2]  <= i_cfg_data;
                CFG_NX:  r_nrm[0] <= i_cfg_data;
                CFG_NY:  r_nrm[1] <= i_cfg_data;
                CFG_NZ:  r_nrm[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the pipeline moves as a whole; it holds only when a result cannot leave
    assign w_en = !r_dly_vld[ISECT_LAT-1] || (r_dly[ISECT_LAT-1].mode == MODE_CULL)
                  || w_take_ok;
    assign s_axis_tready = w_en;

    for (genvar gi = 0; gi < 3; gi++) begin : g_dist
        tpc_dist_lane u_dist (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_vert   (r_s0_v[gi]),
            .i_point  (r_pp),
            .i_normal (r_nrm),
            .o_dist   (w_dist[gi])
        );
    end

    // sort vertices into inside and outside, keeping input order
    always_comb begin
        logic [1:0] n_in;
        logic [1:0] n_out;
        logic [1:0] ia0;
        logic [1:0] ia1;
        logic [1:0] ob0;
        logic [1:0] ob1;
        logic [1:0] l1_in;
        logic [1:0] l1_out;
        n_in  = '0;
        n_out = '0;
        ia0   = '0;
        ia1   = '0;
        ob0   = '0;
        ob1   = '0;
        for (int i = 0; i < 3; i++) begin
            if (!w_dist[i][DIST_W-1]) begin
                if (n_in == 2'd0) begin
                    ia0 = 2'(i);
                end else if (n_in == 2'd1) begin
                    ia1 = 2'(i);
                end
                n_in = n_in + 2'd1;
            end else begin
                if (n_out == 2'd0) begin
                    ob0 = 2'(i);
                end else begin
                    ob1 = 2'(i);
                end
                n_out = n_out + 2'd1;
            end
        end
        unique case (n_in)
            2'd0: n_s3_side.mode = MODE_CULL;
            2'd1: n_s3_side.mode = MODE_ONE;
            2'd2: n_s3_side.mode = MODE_TWO;
            2'd3: n_s3_side.mode = MODE_PASS;
        endcase
        if (r_nrm == '0) begin
            n_s3_side.mode = MODE_CULL;
        end
        n_s3_side.p0 = r_s2_v[ia0];
        n_s3_side.p1 = r_s2_v[ia1];
        n_s3_side.p2 = r_s2_v[2];
        l1_in  = (n_in == 2'd2) ? ia1 : ia0;
        l1_out = (n_in == 2'd2) ? ob0 : ob1;
        n_l_vin[0]  = r_s2_v[ia0];
        n_l_vout[0] = r_s2_v[ob0];
        n_l_num[0]  = w_dist[ia0];
        n_l_den[0]  = DEN_W'(w_dist[ia0]) - DEN_W'(w_dist[ob0]);
        n_l_vin[1]  = r_s2_v[l1_in];
        n_l_vout[1] = r_s2_v[l1_out];
        n_l_num[1]  = w_dist[l1_in];
        n_l_den[1]  = DEN_W'(w_dist[l1_in]) - DEN_W'(w_dist[l1_out]);
    end

    for (genvar gl = 0; gl < 2; gl++) begin : g_isect
        tpc_isect_lane u_isect (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_vin  (r_l_vin[gl]),
            .i_vout (r_l_vout[gl]),
            .i_num  (r_l_num[gl]),
            .i_den  (r_l_den[gl]),
            .o_pt   (w_x[gl])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            for (int i = 0; i < ISECT_LAT; i++) begin
                r_dly_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_s0_vld     <= s_axis_tvalid;
            r_s1_vld     <= r_s0_vld;
            r_s2_vld     <= r_s1_vld;
            r_s3_vld     <= r_s2_vld;
            r_dly_vld[0] <= r_s3_vld;
            for (int i = 1; i < ISECT_LAT; i++) begin
                r_dly_vld[i] <= r_dly_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_v    <= s_axis_tdata;
            r_s1_v    <= r_s0_v;
            r_s2_v    <= r_s1_v;
            r_s3_side <= n_s3_side;
            r_l_vin   <= n_l_vin;
            r_l_vout  <= n_l_vout;
            r_l_num   <= n_l_num;
            r_l_den   <= n_l_den;
            r_dly[0]  <= r_s3_side;
            for (int i = 1; i < ISECT_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    tpc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_dly_vld[ISECT_LAT-1]),
        .i_side    (r_dly[ISECT_LAT-1]),
        .i_x0      (w_x[0]),
        .i_x1      (w_x[1]),
        .i_ready   (m_axis_tready),
        .o_take_ok (w_take_ok),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

    // the second triangle of a quad is ready right after the first leaves
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("second triangle missing after non-final transaction");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dly_vld[ISECT_LAT-1] && (r_dly[ISECT_LAT-1].mode != MODE_CULL)
         && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a result is blocked");

    a_cull_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dly_vld[ISECT_LAT-1] && (r_dly[ISECT_LAT-1].mode == MODE_CULL))
        |-> s_axis_tready)
        else $error("culled triangle stalls the pipeline");

endmodule

// ===== sv/tpc_dist_lane.sv =====
// ----------------------------------------------------------------------------
// tpc_dist_lane
// Signed distance of one vertex to the plane, n . (v - p), two stages.
// ----------------------------------------------------------------------------
module tpc_dist_lane import tpc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_vec  i_vert,
    input  t_vec  i_point,
    input  t_vec  i_normal,
    output t_dist o_dist
);

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [PROD_W-1:0] n_prod [3];
    t_dist                    r_dist;
    t_dist                    n_dist;

    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        for (int k = 0; k < 3; k++) begin
            diff = DIFF_W'($signed(i_vert[k])) - DIFF_W'($signed(i_point[k]));
            n_prod[k] = diff * $signed(i_normal[k]);
        end
    end

    assign n_dist = DIST_W'(r_prod[0]) + DIST_W'(r_prod[1]) + DIST_W'(r_prod[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_dist <= n_dist;
        end
    end

    assign o_dist = r_dist;

endmodule

// ===== sv/tpc_isect_lane.sv =====
// ----------------------------------------------------------------------------
// tpc_isect_lane
// Point where one edge meets the plane: normalize, restoring divide for t,
// then interpolate with rounding and saturation. Fully pipelined.
// ----------------------------------------------------------------------------
module tpc_isect_lane import tpc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_vec                    i_vin,
    input  t_vec                    i_vout,
    input  t_dist                   i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output t_vec                    o_pt
);

    localparam int MUL_W = 2 * COORD_W;
    localparam int Q_W   = MUL_W - T_FRAC;
    localparam int S_W   = Q_W + 1;
    localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(1) << (T_FRAC - 1);

    typedef struct packed {
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_nd;

    typedef logic [2:0][DIFF_W-1:0] t_dvec;

    // shift both by k while the divisor is still at least 2^(T_FRAC+k)
    function automatic t_nd norm_step(t_nd a, int k);
        t_nd r;
        r = a;
        if (a.den >= (DEN_W'(1) << (T_FRAC + k))) begin
            r.num = a.num >> k;
            r.den = a.den >> k;
        end
        return r;
    endfunction

    t_nd                    r_nd   [NORM_STAGES];
    t_nd                    n_nd   [NORM_STAGES];
    logic [T_W-1:0]         r_rem  [DIV_STAGES];
    logic [T_W-1:0]         n_rem  [DIV_STAGES];
    logic [T_W-1:0]         r_q    [DIV_STAGES];
    logic [T_W-1:0]         n_q    [DIV_STAGES];
    logic [T_W-1:0]         r_dv   [DIV_STAGES];
    logic [T_W-1:0]         n_dv   [DIV_STAGES];
    t_vec                   r_cvin [CARRY_N];
    t_vec                   n_cvin [CARRY_N];
    t_dvec                  r_cdif [CARRY_N];
    t_dvec                  n_cdif [CARRY_N];
    logic signed [MUL_W-1:0] r_prod [3];
    logic signed [MUL_W-1:0] n_prod [3];
    t_vec                   r_pt;
    t_vec                   n_pt;

    // normalization: shifts of 32,16 / 8,4 / 2,1
    always_comb begin
        t_nd start;
        start.num = {1'b0, i_num};
        start.den = i_den;
        n_nd[0] = norm_step(norm_step(start, 32), 16);
        n_nd[1] = norm_step(norm_step(r_nd[0], 8), 4);
        n_nd[2] = norm_step(norm_step(r_nd[1], 2), 1);
    end

    // one quotient bit per stage, numerator never exceeds the divisor
    always_comb begin
        logic [T_W:0]   two;
        logic [T_W-1:0] nn;
        logic [T_W-1:0] dd;
        nn = r_nd[NORM_STAGES-1].num[T_W-1:0];
        dd = r_nd[NORM_STAGES-1].den[T_W-1:0];
        n_dv[0] = dd;
        if (nn >= dd) begin
            n_rem[0] = nn - dd;
            n_q[0]   = T_W'(1);
        end else begin
            n_rem[0] = nn;
            n_q[0]   = '0;
        end
        for (int j = 1; j < DIV_STAGES; j++) begin
            two     = {r_rem[j-1], 1'b0};
            n_dv[j] = r_dv[j-1];
            if (two >= {1'b0, r_dv[j-1]}) begin
                n_rem[j] = T_W'(two - {1'b0, r_dv[j-1]});
                n_q[j]   = {r_q[j-1][T_W-2:0], 1'b1};
            end else begin
                n_rem[j] = two[T_W-1:0];
                n_q[j]   = {r_q[j-1][T_W-2:0], 1'b0};
            end
        end
    end

    // inside vertex and edge vector travel beside the divider
    always_comb begin
        n_cvin[0] = i_vin;
        for (int k = 0; k < 3; k++) begin
            n_cdif[0][k] = DIFF_W'($signed(i_vout[k])) - DIFF_W'($signed(i_vin[k]));
        end
        for (int s = 1; s < CARRY_N; s++) begin
            n_cvin[s] = r_cvin[s-1];
            n_cdif[s] = r_cdif[s-1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = $signed(r_cdif[CARRY_N-2][k]) * $signed({1'b0, r_q[DIV_STAGES-1]});
        end
    end

    // round half up, add to the inside vertex, clamp to 32 bits
    always_comb begin
        logic signed [MUL_W-1:0] rnd;
        logic signed [Q_W-1:0]   q;
        logic signed [S_W-1:0]   s;
        for (int k = 0; k < 3; k++) begin
            rnd = r_prod[k] + RND_HALF;
            q   = $signed(rnd[MUL_W-1:T_FRAC]);
            s   = S_W'($signed(r_cvin[CARRY_N-1][k])) + S_W'(q);
            if ((&s[S_W-1:COORD_W-1]) || !(|s[S_W-1:COORD_W-1])) begin
                n_pt[k] = s[COORD_W-1:0];
            end else if (s[S_W-1]) begin
                n_pt[k] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n_pt[k] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nd   <= n_nd;
            r_rem  <= n_rem;
            r_q    <= n_q;
            r_dv   <= n_dv;
            r_cvin <= n_cvin;
            r_cdif <= n_cdif;
            r_prod <= n_prod;
            r_pt   <= n_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

// ===== sv/tpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// tpc_out_stage
// Merges pass-through vertices and lane intersections into result
// triangles; output register plus one held second triangle.
// ----------------------------------------------------------------------------
module tpc_out_stage import tpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_side            i_side,
    input  t_vec             i_x0,
    input  t_vec             i_x1,
    input  logic             i_ready,
    output logic             o_take_ok,
    output logic             o_valid,
    output logic [TRI_W-1:0] o_data,
    output logic             o_last
);

    logic             r_out_vld;
    logic             n_out_vld;
    logic             r_sec_vld;
    logic             n_sec_vld;
    logic [TRI_W-1:0] r_out_data;
    logic [TRI_W-1:0] n_out_data;
    logic             r_out_last;
    logic             n_out_last;
    logic [TRI_W-1:0] r_sec_data;
    logic [TRI_W-1:0] n_sec_data;
    logic [TRI_W-1:0] w_first;
    logic [TRI_W-1:0] w_second;
    logic             w_first_last;
    logic             w_take;

    always_comb begin
        w_second     = {i_x1, i_x0, i_side.p1};
        w_first      = {i_side.p2, i_side.p1, i_side.p0};
        w_first_last = 1'b1;
        unique case (i_side.mode)
            MODE_CULL: w_first = {i_side.p2, i_side.p1, i_side.p0};
            MODE_PASS: w_first = {i_side.p2, i_side.p1, i_side.p0};
            MODE_ONE:  w_first = {i_x1, i_x0, i_side.p0};
            MODE_TWO: begin
                w_first      = {i_x0, i_side.p1, i_side.p0};
                w_first_last = 1'b0;
            end
        endcase
    end

    assign o_take_ok = !r_out_vld || (i_ready && !r_sec_vld);
    assign w_take    = i_vld && o_take_ok && (i_side.mode != MODE_CULL);

    always_comb begin
        n_out_vld  = r_out_vld;
        n_sec_vld  = r_sec_vld;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        n_sec_data = r_sec_data;
        if (r_out_vld && i_ready) begin
            if (r_sec_vld) begin
                n_out_data = r_sec_data;
                n_out_last = 1'b1;
                n_sec_vld  = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (w_take) begin
            n_out_vld  = 1'b1;
            n_out_data = w_first;
            n_out_last = w_first_last;
            if (i_side.mode == MODE_TWO) begin
                n_sec_vld  = 1'b1;
                n_sec_data = w_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sec_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_sec_vld <= n_sec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_sec_data <= n_sec_data;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule
